@@ hdl/stl_pkg.sv @@
// Shared types and constants for the source token lexer.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package stl_pkg;

  localparam int KW_SLOTS   = 7;              // slots searched
  localparam int KW_REGS    = 7;              // keyword registers on the config port
  localparam int KW_CHARS   = 8;              // characters kept per identifier
  localparam int LEAD_W     = 8 * KW_CHARS;
  localparam int KW_W       = 64;
  localparam int POS_W      = 16;             // line and column counters
  localparam int LEN_W      = 16;
  localparam int VAL_W      = 63;
  localparam int SLOT_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KW_FIRST = 3'd1;

  typedef enum logic [2:0] {
    KIND_EOF     = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_INT     = 3'd2,
    KIND_CHAR    = 3'd3,
    KIND_KEYWORD = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_INT
  } mode_e;

  typedef struct packed {
    logic [SLOT_W-1:0]             count;
    logic [KW_REGS-1:0][KW_W-1:0]  kw;
  } cfg_t;

  typedef struct packed {
    kind_e        kind;
    logic [2:0]   slot;
    logic [7:0]   ch;
    logic [62:0]  value;
    logic         ovf;
    logic [15:0]  len;
    logic [15:0]  line;
    logic [15:0]  col;
    logic         last;
  } token_t;

  // up to two tokens per byte: a closed pending token, then eof or a char token
  typedef struct packed {
    logic   a_valid;
    token_t a;
    logic   b_valid;
    token_t b;
  } push_t;

endpackage

@@ hdl/stl_cfg_regs.sv @@
// Configuration registers: keyword count and keyword slots.
// Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [stl_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [stl_pkg::CFG_DATA_W-1:0] wdata_i,
  output stl_pkg::cfg_t                  cfg_o
);

  stl_pkg::cfg_t cfg_d, cfg_q;
  logic [stl_pkg::CFG_IDX_W-1:0] kw_sel;

  assign kw_sel = idx_i - stl_pkg::CFG_KW_FIRST;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        stl_pkg::CFG_KW_COUNT: cfg_d.count = wdata_i[stl_pkg::SLOT_W-1:0];
        default:               cfg_d.kw[kw_sel] = wdata_i[stl_pkg::KW_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/stl_kw_match.sv @@
// Keyword lookup: compares the leading characters with the active slots,
// first match wins. Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_kw_match (
  input  stl_pkg::cfg_t                cfg_i,
  input  logic [stl_pkg::LEAD_W-1:0]   lead_i,
  input  logic                         len_ok_i,
  output logic                         hit_o,
  output logic [stl_pkg::SLOT_W-1:0]   slot_o
);

  always_comb begin
    hit_o  = 1'b0;
    slot_o = '0;
    // walk downward so the lowest matching slot ends up selected
    for (int i = stl_pkg::KW_SLOTS - 1; i >= 0; i--) begin
      if (len_ok_i && (stl_pkg::SLOT_W'(i) < cfg_i.count) &&
          (cfg_i.kw[i][stl_pkg::LEAD_W-1:0] == lead_i)) begin
        hit_o  = 1'b1;
        slot_o = stl_pkg::SLOT_W'(i);
      end
    end
  end

endmodule

@@ hdl/stl_scan.sv @@
// Scanner state and token forming for one byte per cycle, on each cycle that fire_i transfers a byte.
// Depends on stl_pkg and stl_kw_match.
`timescale 1ns / 1ps

module stl_scan (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  logic [7:0]      byte_i,
  input  logic            eoi_i,
  input  stl_pkg::cfg_t   cfg_i,
  output stl_pkg::push_t  push_o
);

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_NINE       = 8'h39;
  localparam logic [7:0] CH_LF         = 8'h0A;
  localparam logic [7:0] CH_CR         = 8'h0D;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_LOW_A      = 8'h61;
  localparam logic [7:0] CH_LOW_Z      = 8'h7A;
  localparam logic [7:0] CH_UP_A       = 8'h41;
  localparam logic [7:0] CH_UP_Z       = 8'h5A;

  localparam int MUL_W = stl_pkg::VAL_W + 4;
  localparam logic [stl_pkg::POS_W-1:0] POS_ONE = stl_pkg::POS_W'(1);

  stl_pkg::mode_e                  mode_d, mode_q;
  logic [stl_pkg::POS_W-1:0]       line_d, line_q, col_d, col_q;
  logic [stl_pkg::POS_W-1:0]       pline_d, pline_q, pcol_d, pcol_q;
  logic [stl_pkg::LEN_W-1:0]       plen_d, plen_q;
  logic [stl_pkg::LEAD_W-1:0]      lead_d, lead_q;
  logic [stl_pkg::VAL_W-1:0]       val_d, val_q;
  logic                            ovf_d, ovf_q;

  logic is_letter, is_digit, is_head, is_body, is_space, end_w;
  logic cont_ident, cont_int, closing, is_char;
  logic [stl_pkg::POS_W-1:0]  adv_line, adv_col;
  logic [stl_pkg::LEN_W-1:0]  plen_inc;
  logic                       kw_hit;
  logic [stl_pkg::SLOT_W-1:0] kw_slot;
  logic [MUL_W-1:0]           acc;
  logic [stl_pkg::VAL_W-1:0]  digit;

  assign is_letter = ((byte_i >= CH_LOW_A) && (byte_i <= CH_LOW_Z)) ||
                     ((byte_i >= CH_UP_A) && (byte_i <= CH_UP_Z));
  assign is_digit  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_head   = is_letter || (byte_i == CH_UNDERSCORE);
  assign is_body   = is_head || is_digit;
  assign is_space  = (byte_i == CH_SPACE) || ((byte_i >= CH_TAB) && (byte_i <= CH_CR));
  assign end_w     = eoi_i || (byte_i == 8'h00);

  assign cont_ident = (mode_q == stl_pkg::MODE_IDENT) && is_body;
  assign cont_int   = (mode_q == stl_pkg::MODE_INT) && is_digit;
  assign closing    = (mode_q != stl_pkg::MODE_IDLE) && (end_w || !(cont_ident || cont_int));
  assign is_char    = !end_w && !cont_ident && !cont_int && !is_space && !is_body;

  // column steps, saturating, on every consumed byte that does not end the input; CR and LF return it to 1
  always_comb begin
    adv_line = line_q;
    adv_col  = (col_q != '1) ? col_q + POS_ONE : col_q;
    if ((byte_i == CH_CR) || (byte_i == CH_LF)) begin
      adv_col = POS_ONE;
      if ((byte_i == CH_LF) && (line_q != '1)) adv_line = line_q + POS_ONE;
    end
  end

  assign plen_inc = (plen_q != '1) ? plen_q + stl_pkg::LEN_W'(1) : plen_q;

  // value * 10 + digit, with room to spot saturation
  assign digit = stl_pkg::VAL_W'(byte_i - CH_ZERO);
  assign acc   = (MUL_W'(val_q) << 3) + (MUL_W'(val_q) << 1) + MUL_W'(digit);

  stl_kw_match u_kw_match (
    .cfg_i    (cfg_i),
    .lead_i   (lead_q),
    .len_ok_i (plen_q <= stl_pkg::LEN_W'(stl_pkg::KW_CHARS)),
    .hit_o    (kw_hit),
    .slot_o   (kw_slot)
  );

  always_comb begin
    push_o = '0;

    push_o.a_valid = fire_i && closing;
    push_o.a.kind  = (mode_q == stl_pkg::MODE_INT) ? stl_pkg::KIND_INT :
                     (kw_hit ? stl_pkg::KIND_KEYWORD : stl_pkg::KIND_IDENT);
    push_o.a.slot  = ((mode_q == stl_pkg::MODE_IDENT) && kw_hit) ? kw_slot : '0;
    push_o.a.value = (mode_q == stl_pkg::MODE_INT) ? val_q : '0;
    push_o.a.ovf   = (mode_q == stl_pkg::MODE_INT) && ovf_q;
    push_o.a.len   = 16'(plen_q);
    push_o.a.line  = 16'(pline_q);
    push_o.a.col   = 16'(pcol_q);

    push_o.b_valid = fire_i && (end_w || is_char);
    push_o.b.kind  = end_w ? stl_pkg::KIND_EOF : stl_pkg::KIND_CHAR;
    push_o.b.ch    = end_w ? 8'h00 : byte_i;
    push_o.b.len   = end_w ? 16'd0 : 16'd1;
    push_o.b.line  = 16'(line_q);
    push_o.b.col   = 16'(col_q);
    push_o.b.last  = 1'b1;

    push_o.a.last  = !push_o.b_valid;
  end

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    pline_d = pline_q;
    pcol_d  = pcol_q;
    plen_d  = plen_q;
    lead_d  = lead_q;
    val_d   = val_q;
    ovf_d   = ovf_q;
    if (fire_i) begin
      if (end_w) begin
        mode_d  = stl_pkg::MODE_IDLE;
        line_d  = POS_ONE;
        col_d   = POS_ONE;
        pline_d = POS_ONE;
        pcol_d  = POS_ONE;
        plen_d  = '0;
        lead_d  = '0;
        val_d   = '0;
        ovf_d   = 1'b0;
      end else if (cont_ident) begin
        for (int j = 0; j < stl_pkg::KW_CHARS; j++) begin
          if (plen_q == stl_pkg::LEN_W'(j)) lead_d[8*j +: 8] = lead_q[8*j +: 8] | byte_i;
        end
        plen_d = plen_inc;
        line_d = adv_line;
        col_d  = adv_col;
      end else if (cont_int) begin
        if (acc > MUL_W'({stl_pkg::VAL_W{1'b1}})) begin
          val_d = '1;
          ovf_d = 1'b1;
        end else begin
          val_d = acc[stl_pkg::VAL_W-1:0];
        end
        plen_d = plen_inc;
        line_d = adv_line;
        col_d  = adv_col;
      end else begin
        mode_d = stl_pkg::MODE_IDLE;
        if (!is_space) begin
          pline_d = line_q;
          pcol_d  = col_q;
          plen_d  = stl_pkg::LEN_W'(1);
          if (is_head) begin
            mode_d = stl_pkg::MODE_IDENT;
            lead_d = stl_pkg::LEAD_W'(byte_i);
          end else if (is_digit) begin
            mode_d = stl_pkg::MODE_INT;
            val_d  = digit;
            ovf_d  = 1'b0;
          end
        end
        line_d = adv_line;
        col_d  = adv_col;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stl_pkg::MODE_IDLE;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      pline_q <= POS_ONE;
      pcol_q  <= POS_ONE;
      plen_q  <= '0;
      lead_q  <= '0;
      val_q   <= '0;
      ovf_q   <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      pline_q <= pline_d;
      pcol_q  <= pcol_d;
      plen_q  <= plen_d;
      lead_q  <= lead_d;
      val_q   <= val_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

@@ hdl/stl_out_fifo.sv @@
// Result queue: takes up to two tokens per cycle, hands out one per transfer.
// Depends on stl_pkg.
`timescale 1ns / 1ps

module stl_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stl_pkg::push_t  push_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output stl_pkg::token_t token_o
);

  localparam int CNT_W = stl_pkg::FIFO_PTR_W + 1;

  stl_pkg::token_t mem_q [stl_pkg::FIFO_DEPTH];
  logic [stl_pkg::FIFO_PTR_W-1:0] wr_d, wr_q, rd_d, rd_q, b_ptr;
  logic [CNT_W-1:0]               cnt_d, cnt_q;
  logic                           pop;

  assign pop     = valid_o && ready_i;
  assign b_ptr   = wr_q + stl_pkg::FIFO_PTR_W'(push_i.a_valid);
  assign valid_o = (cnt_q != '0);
  assign token_o = mem_q[rd_q];
  // room for a full pair, independent of the output side this cycle
  assign room_o  = (cnt_q <= CNT_W'(stl_pkg::FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + stl_pkg::FIFO_PTR_W'(push_i.a_valid) +
            stl_pkg::FIFO_PTR_W'(push_i.b_valid);
    rd_d  = rd_q + stl_pkg::FIFO_PTR_W'(pop);
    cnt_d = cnt_q + CNT_W'(push_i.a_valid) + CNT_W'(push_i.b_valid) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.a_valid) mem_q[wr_q] <= push_i.a;
    if (push_i.b_valid) mem_q[b_ptr] <= push_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ hdl/source_token_lexer_top.sv @@
// Source token lexer: a token enters the result queue at the byte transfer that ends it.
// One byte per cycle; input is held off only while the four-entry result queue
// lacks room for two tokens (a closed token plus a char or end-of-file token).
// Reset clears the queue, sets line and column to 1 and keyword registers to zero.
// Uses stl_pkg, stl_cfg_regs, stl_scan and stl_out_fifo.
`timescale 1ns / 1ps

module source_token_lexer_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stl_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,   // source_byte
  input  logic                           s_axis_tlast,   // end_of_input
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // keyword_slot, char_code, int_value, value_overflow, token_length,
  // start_line, start_column, zero fill
  output logic [127:0]                   m_axis_tdata,
  output logic [2:0]                     m_axis_tuser,   // token_kind
  output logic                           m_axis_tlast    // last_of_run
);

  stl_pkg::cfg_t   cfg;
  stl_pkg::push_t  push;
  stl_pkg::token_t tok;
  logic            fire;

  assign fire = s_axis_tvalid && s_axis_tready;

  stl_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  stl_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .eoi_i  (s_axis_tlast),
    .cfg_i  (cfg),
    .push_o (push)
  );

  stl_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .token_o (tok)
  );

  assign m_axis_tdata = {5'b0, tok.col, tok.line, tok.len, tok.ovf, tok.value,
                         tok.ch, tok.slot};
  assign m_axis_tuser = tok.kind;
  assign m_axis_tlast = tok.last;

endmodule

@@ test/tb.sv @@
// Self-checking testbench for source_token_lexer_top: drives source bytes, checks tokens.
// Keeps its own behavioral lexer to predict tokens; depends on stl_pkg and the top module.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       drain;   // hold this byte back until every pending token is out
    logic [4:0] gap;     // idle cycles ahead of this byte
  } src_byte_t;

  localparam logic [63:0] VALUE_SAT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [15:0] POS_SAT   = 16'hFFFF;
  localparam logic [7:0]  CH_TAB    = 8'h09;
  localparam logic [7:0]  CH_LF     = 8'h0A;
  localparam logic [7:0]  CH_VT     = 8'h0B;
  localparam logic [7:0]  CH_FF     = 8'h0C;
  localparam logic [7:0]  CH_CR     = 8'h0D;
  localparam logic [7:0]  CH_SP     = 8'h20;
  localparam logic [7:0]  CH_US     = 8'h5F;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [stl_pkg::CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [stl_pkg::CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;   // source_byte
  logic                           s_axis_tlast = 1'b0; // end_of_input
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  // keyword_slot, char_code, int_value, value_overflow, token_length,
  // start_line, start_column, zero fill
  logic [127:0]                   m_axis_tdata;
  logic [2:0]                     m_axis_tuser;        // token_kind
  logic                           m_axis_tlast;        // last_of_run

  source_token_lexer_top DUT (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  // stimulus and bookkeeping
  src_byte_t       byte_q[$];
  src_byte_t       next_byte;
  stl_pkg::token_t token_q[$];
  int        src_idle_max = 17;
  int        sink_idle_max = 17;
  int        drain_odds = 0;
  bit        drain_next = 1'b0;
  int        hold_left = 0;
  bit        hold_armed = 1'b0;
  int        sink_wait = 0;
  int        bytes_queued = 0;
  int        bytes_taken = 0;
  int        tokens_seen = 0;
  int        keywords_seen = 0;
  int        sat_ints_seen = 0;
  int        eofs_seen = 0;
  int        errors = 0;

  // lexer mirror
  stl_pkg::mode_e lex_mode = stl_pkg::MODE_IDLE;
  logic [15:0] cur_line = 16'd1;
  logic [15:0] cur_col = 16'd1;
  logic [15:0] tok_line = 16'd1;
  logic [15:0] tok_col = 16'd1;
  logic [15:0] tok_len = '0;
  logic [63:0] tok_chars = '0;
  logic [62:0] tok_value = '0;
  logic        tok_ovf = 1'b0;
  logic [2:0]  kw_count_m = '0;
  logic [63:0] kw_text [stl_pkg::KW_REGS];

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic bit is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_head(logic [7:0] b);
    return b == CH_US || is_letter(b);
  endfunction

  function automatic bit is_space(logic [7:0] b);
    return b == CH_SP || (b >= CH_TAB && b <= CH_CR);
  endfunction

  function automatic void clear_lexer();
    lex_mode  = stl_pkg::MODE_IDLE;
    cur_line  = 16'd1;
    cur_col   = 16'd1;
    tok_line  = 16'd1;
    tok_col   = 16'd1;
    tok_len   = '0;
    tok_chars = '0;
    tok_value = '0;
    tok_ovf   = 1'b0;
  endfunction

  function automatic void advance_pos(logic [7:0] b);
    if (cur_col != POS_SAT) cur_col++;
    if (b == CH_CR || b == CH_LF) begin
      cur_col = 16'd1;
      if (b == CH_LF && cur_line != POS_SAT) cur_line++;
    end
  endfunction

  function automatic void push_token(stl_pkg::kind_e k, logic [2:0] slot, logic [7:0] ch,
                                     logic [62:0] value, logic ovf, logic [15:0] len,
                                     logic [15:0] line, logic [15:0] col);
    stl_pkg::token_t t;
    t.kind  = k;
    t.slot  = slot;
    t.ch    = ch;
    t.value = value;
    t.ovf   = ovf;
    t.len   = len;
    t.line  = line;
    t.col   = col;
    t.last  = 1'b0;
    token_q.push_back(t);
  endfunction

  // emit whatever token is open; identifiers are looked up in the keyword slots
  function automatic void close_token();
    stl_pkg::kind_e k;
    logic [2:0]     slot;
    int             i;
    if (lex_mode == stl_pkg::MODE_IDENT) begin
      k = stl_pkg::KIND_IDENT;
      slot = '0;
      if (tok_len <= stl_pkg::KW_CHARS) begin
        for (i = 0; i < stl_pkg::KW_SLOTS; i++) begin
          if (k == stl_pkg::KIND_IDENT && i < int'(kw_count_m) &&
              kw_text[i] == tok_chars) begin
            k = stl_pkg::KIND_KEYWORD;
            slot = 3'(i);
          end
        end
      end
      push_token(k, slot, '0, '0, 1'b0, tok_len, tok_line, tok_col);
    end else if (lex_mode == stl_pkg::MODE_INT) begin
      push_token(stl_pkg::KIND_INT, '0, '0, tok_value, tok_ovf, tok_len, tok_line, tok_col);
    end
    lex_mode = stl_pkg::MODE_IDLE;
  endfunction

  function automatic void open_token(logic [7:0] b);
    if (is_space(b)) begin
      advance_pos(b);
    end else begin
      tok_line = cur_line;
      tok_col  = cur_col;
      tok_len  = 16'd1;
      if (is_head(b)) begin
        lex_mode  = stl_pkg::MODE_IDENT;
        tok_chars = {56'd0, b};
      end else if (is_digit(b)) begin
        lex_mode  = stl_pkg::MODE_INT;
        tok_value = 63'(b - "0");
        tok_ovf   = 1'b0;
      end else begin
        push_token(stl_pkg::KIND_CHAR, '0, b, '0, 1'b0, 16'd1, cur_line, cur_col);
      end
      advance_pos(b);
    end
  endfunction

  // predicted tokens for one transferred byte
  function automatic void lex_byte(logic [7:0] b, logic eoi);
    int          depth0;
    logic [63:0] digit;
    logic [63:0] wide;
    depth0 = token_q.size();
    if (eoi || b == 8'd0) begin
      close_token();
      push_token(stl_pkg::KIND_EOF, '0, '0, '0, 1'b0, '0, cur_line, cur_col);
      clear_lexer();
    end else if (lex_mode == stl_pkg::MODE_IDENT && (is_head(b) || is_digit(b))) begin
      if (tok_len < stl_pkg::KW_CHARS) tok_chars[8*tok_len +: 8] = b;
      if (tok_len != POS_SAT) tok_len++;
      advance_pos(b);
    end else if (lex_mode == stl_pkg::MODE_INT && is_digit(b)) begin
      digit = 64'(b - "0");
      wide  = {1'b0, tok_value};
      if (wide > (VALUE_SAT - digit) / 10) begin
        tok_value = VALUE_SAT[62:0];
        tok_ovf   = 1'b1;
      end else begin
        wide      = wide * 10 + digit;
        tok_value = wide[62:0];
      end
      if (tok_len != POS_SAT) tok_len++;
      advance_pos(b);
    end else begin
      close_token();
      open_token(b);
    end
    if (token_q.size() > depth0) token_q[token_q.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("tb: token %0d: %s is %0h, expected %0h", tokens_seen, what, got, want);
  endtask

  task automatic check_token();
    stl_pkg::token_t want;
    if (token_q.size() == 0) begin
      report_mismatch("unexpected token of kind", 64'(m_axis_tuser), 64'd0);
      return;
    end
    want = token_q.pop_front();
    tokens_seen++;
    if (want.kind == stl_pkg::KIND_KEYWORD) keywords_seen++;
    if (want.kind == stl_pkg::KIND_EOF) eofs_seen++;
    if (want.kind == stl_pkg::KIND_INT && want.ovf) sat_ints_seen++;
    if (m_axis_tuser != want.kind)
      report_mismatch("kind", 64'(m_axis_tuser), 64'(want.kind));
    if (m_axis_tdata[2:0] != want.slot)
      report_mismatch("slot", 64'(m_axis_tdata[2:0]), 64'(want.slot));
    if (m_axis_tdata[10:3] != want.ch)
      report_mismatch("char", 64'(m_axis_tdata[10:3]), 64'(want.ch));
    if (m_axis_tdata[73:11] != want.value)
      report_mismatch("value", 64'(m_axis_tdata[73:11]), 64'(want.value));
    if (m_axis_tdata[74] != want.ovf)
      report_mismatch("overflow", 64'(m_axis_tdata[74]), 64'(want.ovf));
    if (m_axis_tdata[90:75] != want.len)
      report_mismatch("length", 64'(m_axis_tdata[90:75]), 64'(want.len));
    if (m_axis_tdata[106:91] != want.line)
      report_mismatch("line", 64'(m_axis_tdata[106:91]), 64'(want.line));
    if (m_axis_tdata[122:107] != want.col)
      report_mismatch("column", 64'(m_axis_tdata[122:107]), 64'(want.col));
    if (m_axis_tlast != want.last)
      report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
  endtask

  // source side: one byte per transfer, idle gap drawn per byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      hold_left = 0;
      hold_armed = 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (byte_q.size() != 0 && !hold_armed) begin
        hold_left = int'(byte_q[0].gap);
        hold_armed = 1'b1;
      end
      if (byte_q.size() != 0 && hold_left == 0 &&
          !(byte_q[0].drain && token_q.size() != 0)) begin
        next_byte = byte_q.pop_front();
        hold_armed = 1'b0;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= next_byte.data;
        s_axis_tlast  <= next_byte.eoi;
      end else begin
        if (hold_left != 0) hold_left--;
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // token side: check, then predict from the byte taken at this edge, then pace ready
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_token();
        sink_wait = $urandom_range(0, sink_idle_max);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        bytes_taken++;
        lex_byte(s_axis_tdata, s_axis_tlast);
      end
      if (!m_axis_tready || m_axis_tvalid) begin
        if (sink_wait != 0) begin
          sink_wait--;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  function automatic void send_byte(logic [7:0] b, logic eoi);
    src_byte_t it;
    it.data  = b;
    it.eoi   = eoi;
    it.gap   = 5'($urandom_range(0, src_idle_max));
    it.drain = 1'b0;
    if (drain_next || (drain_odds != 0 && $urandom_range(1, drain_odds) == 1)) begin
      it.drain = 1'b1;
      drain_next = 1'b0;
      if (it.gap == 0) it.gap = 5'd1;
    end
    byte_q.push_back(it);
    bytes_queued++;
  endfunction

  function automatic void send_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endfunction

  function automatic logic [7:0] rand_head();
    int r;
    r = $urandom_range(0, 52);
    if (r == 52) return CH_US;
    if (r < 26) return 8'("a" + r);
    return 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_body();
    int r;
    r = $urandom_range(0, 62);
    if (r < 53) return rand_head();
    return 8'("0" + r - 53);
  endfunction

  function automatic logic [7:0] rand_punct();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (is_head(b) || is_digit(b) || is_space(b));
    return b;
  endfunction

  function automatic logic [63:0] rand_word(int len);
    logic [63:0] w;
    int          i;
    w = '0;
    w[7:0] = rand_head();
    for (i = 1; i < len; i++) w[8*i +: 8] = rand_body();
    return w;
  endfunction

  // keyword text: low byte first, stops at the first zero byte
  function automatic void send_word(logic [63:0] w);
    int i;
    for (i = 0; i < 8; i++) begin
      if (w[8*i +: 8] == 8'd0) break;
      send_byte(w[8*i +: 8], 1'b0);
    end
  endfunction

  // mostly well-formed source text with keywords mixed in, some stray bytes and ends
  function automatic void queue_random_text(int n_items);
    int          start_count;
    int          r;
    int          len;
    int          i;
    logic [63:0] w;
    logic [7:0]  spaces [6];
    spaces = '{CH_SP, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    start_count = bytes_queued;
    while (bytes_queued - start_count < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        w = kw_text[$urandom_range(0, stl_pkg::KW_REGS-1)];
        if ($urandom_range(0, 1) == 1 && is_head(w[7:0])) begin
          send_word(w);
        end else begin
          len = $urandom_range(1, 12);
          send_byte(rand_head(), 1'b0);
          for (i = 1; i < len; i++) send_byte(rand_body(), 1'b0);
        end
      end else if (r < 50) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 6);
        for (i = 0; i < len; i++) send_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
      end else if (r < 75) begin
        send_byte(spaces[$urandom_range(0, 5)], 1'b0);
      end else if (r < 97) begin
        send_byte(rand_punct(), 1'b0);
      end else if ($urandom_range(0, 1) == 1) begin
        send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        send_byte(8'd0, 1'($urandom_range(0, 1)));
      end
    end
  endfunction

  task automatic write_reg(input logic [stl_pkg::CFG_IDX_W-1:0] idx, input logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == stl_pkg::CFG_KW_COUNT) kw_count_m = data[2:0];
    else kw_text[idx - stl_pkg::CFG_KW_FIRST] = data;
  endtask

  task automatic load_keywords(int phase);
    int          i;
    logic [63:0] w;
    if (phase == 0) write_reg(stl_pkg::CFG_KW_COUNT, 64'd0);
    else if (phase == 1) write_reg(stl_pkg::CFG_KW_COUNT, 64'hFFFF_FFFF_FFFF_FFFF);
    else write_reg(stl_pkg::CFG_KW_COUNT, 64'($urandom_range(0, 7)));
    for (i = 0; i < stl_pkg::KW_REGS; i++) begin
      case ($urandom_range(0, 9))
        6:       w = '0;
        7:       w = '1;
        8:       w = {$urandom, $urandom};
        9:       w = rand_word($urandom_range(1, 7)) << 8;   // zero ahead of the text
        default: w = rand_word($urandom_range(1, 8));
      endcase
      write_reg(stl_pkg::CFG_KW_FIRST + 3'(i), w);
    end
  endtask

  // wait for the source queue and all tokens, then let the pipeline empty
  task automatic settle();
    while (byte_q.size() != 0 || s_axis_tvalid || token_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int p;
    int c;
    int modes [3];
    modes = '{0, 4, 17};
    for (p = 0; p < stl_pkg::KW_REGS; p++) kw_text[p] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // registers still at reset: nothing is a keyword
    send_text("if");
    send_byte("q", 1'b1);
    settle();

    write_reg(stl_pkg::CFG_KW_COUNT, 64'd7);
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd0, 64'h0);                  // empty slot never matches
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd1, 64'h6669);               // "if"
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd2, 64'h6867_6665_6463_6261); // "abcdefgh"
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd3, 64'h6100);               // zero byte, then "a"
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd4, 64'h6669);               // duplicate, slot 1 wins
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd5, '1);
    write_reg(stl_pkg::CFG_KW_FIRST + 3'd6, 64'h39_5A5F);            // "_Z9"
    send_text("if _Z9 abcdefgh abcdefghi a");
    send_byte(8'd0, 1'b0);
    drain_next = 1'b1;
    send_text("x1");
    send_byte(CH_TAB, 1'b0);
    send_text("7+");
    send_byte(CH_VT, 1'b0);
    send_byte(CH_FF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_byte(CH_LF, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_text("9223372036854775808");
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    settle();

    drain_odds = 120;
    for (p = 0; p < 8; p++) begin
      load_keywords(p);
      for (c = 0; c < 2; c++) begin
        src_idle_max = modes[$urandom_range(0, 2)];
        sink_idle_max = modes[$urandom_range(0, 2)];
        drain_next = 1'b1;
        queue_random_text(110);
        while (byte_q.size() != 0) @(posedge clk_i);
      end
      send_byte(8'($urandom_range(0, 255)), 1'b1);
      settle();
    end

    $display("tb: %0d bytes in, %0d tokens checked: %0d keywords, %0d saturated ints, %0d eof",
             bytes_taken, tokens_seen, keywords_seen, sat_ints_seen, eofs_seen);
    $display("tb: covered reset and directed keyword slots, 8 random keyword loads, mixed stalls");
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/stl_pkg.sv
hdl/stl_cfg_regs.sv
hdl/stl_kw_match.sv
hdl/stl_scan.sv
hdl/stl_out_fifo.sv
hdl/source_token_lexer_top.sv
test/tb.sv
